// ----- rtl/brb_pkg.sv -----
// Shared types, codes and widths for the circular byte buffer.
package brb_pkg;

    // Fixed field widths
    localparam int LEN_W  = 7;
    localparam int CAP_W  = 13;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // Parameter defaults
    localparam int DEPTH_DEF    = 4096;
    localparam int MAX_XFER_DEF = 64;

    // Capacity after reset, before clamping to the depth
    localparam int CAP_RESET = 4096;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_PREREAD = 2'd2,
        OP_DISCARD = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NO_DATA  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // One result beat from the controller to the output ports
    typedef struct packed {
        logic              strobe;
        status_t           status;
        logic              has_byte;
        logic [LEN_W-1:0]  done_length;
        logic              last;
        logic [CAP_W-1:0]  fill_level;
    } result_t;

endpackage

// ----- rtl/brb_store.sv -----
// Byte storage: single-port synchronous RAM with a registered read.
module brb_store #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic                      re,
    input  logic [AW-1:0]             addr,
    input  logic [brb_pkg::BYTE_W-1:0] wdata,
    output logic [brb_pkg::BYTE_W-1:0] rdata
);

    logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- rtl/brb_ctrl.sv -----
// Cursor, fill and transfer bookkeeping plus the read sequencer.
module brb_ctrl #(
    parameter int DEPTH    = brb_pkg::DEPTH_DEF,
    parameter int MAX_XFER = brb_pkg::MAX_XFER_DEF,
    parameter int AW       = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic [brb_pkg::CAP_W-1:0]  cap,
    input  logic                       start,
    input  brb_pkg::op_t               op,
    input  logic [brb_pkg::LEN_W-1:0]  xfer_length,
    input  logic [brb_pkg::BYTE_W-1:0] data_byte,
    output logic                       busy,
    output logic                       mem_we,
    output logic                       mem_re,
    output logic [AW-1:0]              mem_addr,
    output logic [brb_pkg::BYTE_W-1:0] mem_wdata,
    output brb_pkg::result_t           result
);

    // Arithmetic width covering both cursors and the 13-bit counts
    localparam int MW = ((AW > brb_pkg::CAP_W) ? AW : brb_pkg::CAP_W) + 1;
    localparam logic [brb_pkg::LEN_W-1:0] MAX_LEN = brb_pkg::LEN_W'(MAX_XFER);

    brb_pkg::state_t             state_reg, state_next;
    logic [AW-1:0]               wc_reg, wc_next;
    logic [brb_pkg::CAP_W-1:0]   used_reg, used_next;
    logic [brb_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic                        acc_reg, acc_next;
    logic [brb_pkg::LEN_W-1:0]   total_reg, total_next;
    logic [AW-1:0]               ridx_reg, ridx_next;
    logic [brb_pkg::LEN_W-1:0]   rcnt_reg, rcnt_next;
    logic [brb_pkg::LEN_W-1:0]   rlen_reg, rlen_next;
    brb_pkg::result_t            res_reg, res_next;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brb_pkg::S_IDLE;
            wc_reg    <= '0;
            used_reg  <= '0;
            rem_reg   <= '0;
            acc_reg   <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wc_reg    <= wc_next;
            used_reg  <= used_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            res_reg   <= res_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        ridx_reg  <= ridx_next;
        rcnt_reg  <= rcnt_next;
        rlen_reg  <= rlen_next;
    end

    // Next state, memory access and result
    always_comb
    begin
        logic [brb_pkg::LEN_W-1:0] len_in;
        logic [brb_pkg::LEN_W-1:0] rem_w;
        logic                      acc_w;
        logic [MW-1:0]             cap_w;
        logic [MW-1:0]             used_w;
        logic [MW-1:0]             wc_w;
        logic [MW-1:0]             wc_inc;
        logic [MW-1:0]             ridx_inc;
        logic [MW-1:0]             rc_w;

        len_in   = (xfer_length > MAX_LEN) ? MAX_LEN : xfer_length;
        cap_w    = MW'(cap);
        used_w   = MW'(used_reg);
        wc_w     = MW'(wc_reg);
        wc_inc   = wc_w + MW'(1);
        ridx_inc = MW'(ridx_reg) + MW'(1);
        rc_w     = (wc_w >= used_w) ? (wc_w - used_w) : (wc_w + cap_w - used_w);
        rem_w    = rem_reg;
        acc_w    = acc_reg;

        state_next = state_reg;
        wc_next    = wc_reg;
        used_next  = used_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        ridx_next  = ridx_reg;
        rcnt_next  = rcnt_reg;
        rlen_next  = rlen_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = wc_reg;
        mem_wdata  = data_byte;
        res_next   = '0;

        unique case (state_reg)
            brb_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        brb_pkg::OP_WRITE:
                        begin
                            if (rem_reg == '0 && len_in == '0)
                            begin
                                // Empty transfer completes at once
                                acc_next            = 1'b0;
                                res_next.strobe     = 1'b1;
                                res_next.status     = brb_pkg::ST_OK;
                                res_next.last       = 1'b1;
                                res_next.fill_level = used_reg;
                            end
                            else
                            begin
                                // First beat decides admission of the whole transfer
                                if (rem_reg == '0)
                                begin
                                    acc_w      = (MW'(len_in) <= cap_w - used_w);
                                    rem_w      = len_in;
                                    total_next = len_in;
                                end
                                if (acc_w)
                                begin
                                    mem_we    = 1'b1;
                                    wc_next   = (wc_inc >= cap_w) ? '0 : AW'(wc_inc);
                                    used_next = used_reg + brb_pkg::CAP_W'(1);
                                end
                                rem_next            = rem_w - brb_pkg::LEN_W'(1);
                                acc_next            = (rem_w == brb_pkg::LEN_W'(1)) ? 1'b0 : acc_w;
                                res_next.strobe     = 1'b1;
                                res_next.status     = acc_w ? brb_pkg::ST_OK
                                                            : brb_pkg::ST_NO_SPACE;
                                res_next.last       = 1'b1;
                                res_next.fill_level = used_next;
                                if (acc_w && rem_w == brb_pkg::LEN_W'(1))
                                begin
                                    res_next.done_length = (rem_reg == '0) ? len_in
                                                                            : total_reg;
                                end
                            end
                        end
                        brb_pkg::OP_DISCARD:
                        begin
                            // Drop everything held and any open transfer
                            rem_next            = '0;
                            acc_next            = 1'b0;
                            wc_next             = '0;
                            used_next           = '0;
                            res_next.strobe     = 1'b1;
                            res_next.status     = brb_pkg::ST_OK;
                            res_next.last       = 1'b1;
                            res_next.fill_level = '0;
                        end
                        default:
                        begin
                            // Read or preread; abandons any open transfer
                            rem_next = '0;
                            acc_next = 1'b0;
                            if (used_w < MW'(len_in))
                            begin
                                res_next.strobe     = 1'b1;
                                res_next.status     = brb_pkg::ST_NO_DATA;
                                res_next.last       = 1'b1;
                                res_next.fill_level = used_reg;
                            end
                            else if (len_in == '0)
                            begin
                                res_next.strobe     = 1'b1;
                                res_next.status     = brb_pkg::ST_OK;
                                res_next.last       = 1'b1;
                                res_next.fill_level = used_reg;
                            end
                            else
                            begin
                                if (op == brb_pkg::OP_READ)
                                begin
                                    used_next = used_reg - brb_pkg::CAP_W'(len_in);
                                end
                                ridx_next  = AW'(rc_w);
                                rcnt_next  = len_in;
                                rlen_next  = len_in;
                                state_next = brb_pkg::S_READ;
                            end
                        end
                    endcase
                end
            end
            brb_pkg::S_READ:
            begin
                // Issue one byte read per cycle; the RAM registers the data together with the result beat
                mem_re              = 1'b1;
                mem_addr            = ridx_reg;
                ridx_next           = (ridx_inc >= cap_w) ? '0 : AW'(ridx_inc);
                rcnt_next           = rcnt_reg - brb_pkg::LEN_W'(1);
                res_next.strobe     = 1'b1;
                res_next.status     = brb_pkg::ST_OK;
                res_next.has_byte   = 1'b1;
                res_next.fill_level = used_reg;
                if (rcnt_reg == brb_pkg::LEN_W'(1))
                begin
                    res_next.last        = 1'b1;
                    res_next.done_length = rlen_reg;
                    state_next           = brb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = brb_pkg::S_IDLE;
            end
        endcase

        // Capacity write empties the buffer
        if (clear)
        begin
            state_next = brb_pkg::S_IDLE;
            wc_next    = '0;
            used_next  = '0;
            rem_next   = '0;
            acc_next   = 1'b0;
        end
    end

    assign busy   = (state_reg == brb_pkg::S_READ);
    assign result = res_reg;

endmodule

// ----- rtl/byte_ring_buffer_transfers.sv -----
// Top level of the circular byte buffer: capacity register, control and storage.
//
// A write item gives its result in the cycle after start. Discards and refused
// or empty reads also finish without leaving idle. A read or preread of N bytes
// holds busy after it is taken, walking the single RAM port one byte per cycle,
// and its N results follow one per cycle, each registered behind its read, so
// the next item can be started as the last byte appears.
// Results are strobed for exactly one cycle and must be taken then. Writing
// capacity empties the buffer; write it only while no operation is running.
module byte_ring_buffer_transfers #(
    parameter int DEPTH    = brb_pkg::DEPTH_DEF,
    parameter int MAX_XFER = brb_pkg::MAX_XFER_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [brb_pkg::OP_W-1:0]   op,
    input  logic [brb_pkg::LEN_W-1:0]  xfer_length,
    input  logic [brb_pkg::BYTE_W-1:0] data_byte,
    input  logic                       cfg_we,
    input  logic [brb_pkg::CAP_W-1:0]  cfg_wdata,
    output logic                       result_strobe,
    output logic [brb_pkg::ST_W-1:0]   status,
    output logic [brb_pkg::BYTE_W-1:0] read_byte,
    output logic                       has_byte,
    output logic [brb_pkg::LEN_W-1:0]  done_length,
    output logic                       last,
    output logic [brb_pkg::CAP_W-1:0]  fill_level
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [brb_pkg::CAP_W-1:0] CAP_RST =
        brb_pkg::CAP_W'((DEPTH < brb_pkg::CAP_RESET) ? DEPTH : brb_pkg::CAP_RESET);

    logic [brb_pkg::CAP_W-1:0]  cap_reg, cap_next;
    logic                       mem_we;
    logic                       mem_re;
    logic [AW-1:0]              mem_addr;
    logic [brb_pkg::BYTE_W-1:0] mem_wdata;
    logic [brb_pkg::BYTE_W-1:0] mem_rdata;
    brb_pkg::result_t           result;

    // Clamp written capacity into the usable range
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                cap_next = brb_pkg::CAP_W'(1);
            end
            else if (int'(cfg_wdata) > DEPTH)
            begin
                cap_next = brb_pkg::CAP_W'(DEPTH);
            end
            else
            begin
                cap_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RST;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    brb_ctrl #(
        .DEPTH    (DEPTH),
        .MAX_XFER (MAX_XFER),
        .AW       (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (cfg_we),
        .cap         (cap_reg),
        .start       (start),
        .op          (brb_pkg::op_t'(op)),
        .xfer_length (xfer_length),
        .data_byte   (data_byte),
        .busy        (busy),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .result      (result)
    );

    brb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Drive the result beat; the byte comes straight from the RAM read register
    assign result_strobe = result.strobe;
    assign status        = result.status;
    assign has_byte      = result.has_byte;
    assign read_byte     = result.has_byte ? mem_rdata : '0;
    assign done_length   = result.done_length;
    assign last          = result.last;
    assign fill_level    = result.fill_level;

endmodule

// ----- bench/byte_ring_buffer_transfers_tb.sv -----
// Self-checking bench for the circular byte buffer: queued commands, shadow buffer, beat checks.
module byte_ring_buffer_transfers_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import brb_pkg::*;

    // One command beat as presented on the start/busy port
    typedef struct packed {
        op_t                op;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  data;
    } buffer_cmd_t;

    // One result beat as it should appear on the result ports
    typedef struct packed {
        status_t            status;
        logic [BYTE_W-1:0]  read_byte;
        logic               has_byte;
        logic [LEN_W-1:0]   done_length;
        logic               last;
        logic [CAP_W-1:0]   fill_level;
    } out_beat_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     op = '0;
    logic [LEN_W-1:0]    xfer_length = '0;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                cfg_we = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;
    logic                result_strobe;
    logic [ST_W-1:0]     status;
    logic [BYTE_W-1:0]   read_byte;
    logic                has_byte;
    logic [LEN_W-1:0]    done_length;
    logic                last;
    logic [CAP_W-1:0]    fill_level;

    // Command feed, expected beats and run bookkeeping
    buffer_cmd_t  queued_cmds[$];
    out_beat_t    owed_beats[$];
    buffer_cmd_t  on_bus;
    bit           holding = 1'b0;
    int unsigned  gap_pct = 15;
    int unsigned  mismatches = 0;

    // Shadow copy of the buffer state and the capacity register
    logic [BYTE_W-1:0] shadow_mem [DEPTH_DEF];
    int unsigned  sh_cap = CAP_RESET;
    int unsigned  sh_wr = 0;
    int unsigned  sh_used = 0;
    int unsigned  sh_left = 0;
    int unsigned  sh_total = 0;
    bit           sh_admit = 1'b0;

    byte_ring_buffer_transfers i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .xfer_length   (xfer_length),
        .data_byte     (data_byte),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_strobe (result_strobe),
        .status        (status),
        .read_byte     (read_byte),
        .has_byte      (has_byte),
        .done_length   (done_length),
        .last          (last),
        .fill_level    (fill_level)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Queue one result beat; fill level is the shadow count at this point
    function automatic void owe_beat(status_t st, logic [BYTE_W-1:0] b, logic hb,
                                     logic [LEN_W-1:0] dl, logic lst);
        out_beat_t e;
        e.status      = st;
        e.read_byte   = b;
        e.has_byte    = hb;
        e.done_length = dl;
        e.last        = lst;
        e.fill_level  = CAP_W'(sh_used);
        owed_beats.push_back(e);
    endfunction

    // Advance the shadow buffer by one accepted command and queue its beats
    task automatic shadow_step(input op_t cmd, input logic [LEN_W-1:0] len_in,
                               input logic [BYTE_W-1:0] din);
        int unsigned cap;
        int unsigned len;
        int unsigned rd;
        int unsigned n;
        status_t     st;
        logic [LEN_W-1:0] dl;
        cap = (sh_cap == 0) ? 1 : ((sh_cap > DEPTH_DEF) ? DEPTH_DEF : sh_cap);
        len = (len_in > MAX_XFER_DEF) ? MAX_XFER_DEF : len_in;
        if (cmd == OP_WRITE)
        begin
            // empty transfer completes at once and stores nothing
            if (sh_left == 0 && len == 0)
            begin
                sh_admit = 1'b0;
                owe_beat(ST_OK, '0, 1'b0, '0, 1'b1);
                return;
            end
            // first byte decides admission for the whole transfer
            if (sh_left == 0)
            begin
                sh_admit = (len <= cap - sh_used);
                sh_left = len;
                if (sh_admit)
                    sh_total = len;
            end
            if (sh_admit)
            begin
                shadow_mem[sh_wr] = din;
                sh_wr = (sh_wr + 1 >= cap) ? 0 : sh_wr + 1;
                sh_used++;
                st = ST_OK;
            end
            else
            begin
                st = ST_NO_SPACE;
            end
            sh_left--;
            dl = (sh_left == 0 && sh_admit) ? LEN_W'(sh_total) : '0;
            if (sh_left == 0)
                sh_admit = 1'b0;
            owe_beat(st, '0, 1'b0, dl, 1'b1);
            return;
        end

        // any other command drops an open transfer
        sh_left = 0;
        sh_admit = 1'b0;
        if (cmd == OP_DISCARD)
        begin
            sh_wr = 0;
            sh_used = 0;
            owe_beat(ST_OK, '0, 1'b0, '0, 1'b1);
        end
        else if (sh_used < len)
        begin
            owe_beat(ST_NO_DATA, '0, 1'b0, '0, 1'b1);
        end
        else if (len == 0)
        begin
            owe_beat(ST_OK, '0, 1'b0, '0, 1'b1);
        end
        else
        begin
            // walk from the oldest byte; a read frees before the beats report the level
            rd = (sh_wr >= sh_used) ? sh_wr - sh_used : cap - (sh_used - sh_wr);
            if (cmd == OP_READ)
                sh_used -= len;
            for (n = 0; n < len; n++)
            begin
                if (rd >= cap)
                    rd = 0;
                owe_beat(ST_OK, shadow_mem[rd], 1'b1,
                         (n + 1 == len) ? LEN_W'(len) : '0, (n + 1 == len));
                rd++;
            end
        end
    endtask

    // Driver: hold each command until it is taken, then feed the next
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                shadow_step(on_bus.op, on_bus.len, on_bus.data);
                holding = 1'b0;
            end
            if (!holding && queued_cmds.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                on_bus = queued_cmds.pop_front();
                holding = 1'b1;
                op <= on_bus.op;
                xfer_length <= on_bus.len;
                data_byte <= on_bus.data;
            end
            else if (!holding)
            begin
                // scramble the idle command fields
                op <= OP_W'($urandom_range(3));
                xfer_length <= LEN_W'($urandom_range(127));
                data_byte <= BYTE_W'($urandom_range(255));
            end
            start <= holding;
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: every strobed beat must match the oldest owed beat
    always @(posedge clk)
    begin
        out_beat_t e;
        if (rst_n && result_strobe)
        begin
            if (owed_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual status %0d byte %0d",
                         $time, status, read_byte);
                mismatches++;
            end
            else
            begin
                e = owed_beats.pop_front();
                check_field("status", e.status, status);
                check_field("read_byte", e.read_byte, read_byte);
                check_field("has_byte", e.has_byte, has_byte);
                check_field("done_length", e.done_length, done_length);
                check_field("last", e.last, last);
                check_field("fill_level", e.fill_level, fill_level);
            end
        end
    end

    task automatic push_cmd(input op_t o, input int unsigned len, input int unsigned d);
        buffer_cmd_t c;
        c.op = o;
        c.len = LEN_W'(len);
        c.data = BYTE_W'(d);
        queued_cmds.push_back(c);
    endtask

    // Wait until every command is taken and every beat has come back
    task automatic drain();
        while (queued_cmds.size() != 0 || holding || owed_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the capacity register while idle; the buffer empties with it
    task automatic write_capacity(input int unsigned v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= CAP_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        sh_cap = v;
        sh_wr = 0;
        sh_used = 0;
        sh_left = 0;
        sh_admit = 1'b0;
    endtask

    // Mostly whole transfers and reads, with some cut transfers and noise
    task automatic queue_random(input int unsigned goal);
        int unsigned made;
        int unsigned pick;
        int unsigned k;
        int unsigned len;
        int unsigned sent;
        int unsigned i;
        made = 0;
        while (made < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                k = $urandom_range(19);
                if (k == 0)
                    len = 0;
                else if (k < 14)
                    len = $urandom_range(1, 6);
                else if (k < 17)
                    len = $urandom_range(7, 20);
                else if (k < 19)
                    len = $urandom_range(21, 64);
                else
                    len = $urandom_range(65, 127);
                sent = (len > MAX_XFER_DEF) ? MAX_XFER_DEF : len;
                if (sent == 0)
                    sent = 1;
                if (sent > 1 && $urandom_range(9) == 0)
                    sent = $urandom_range(1, sent - 1);
                for (i = 0; i < sent; i++)
                    push_cmd(OP_WRITE, (i == 0) ? len : $urandom_range(127),
                             $urandom_range(255));
                made += sent;
            end
            else
            begin
                if (pick < 70)
                    push_cmd(OP_READ, ($urandom_range(9) == 0) ? $urandom_range(11, 127)
                             : $urandom_range(10), $urandom_range(255));
                else if (pick < 85)
                    push_cmd(OP_PREREAD, ($urandom_range(9) == 0) ? $urandom_range(11, 127)
                             : $urandom_range(10), $urandom_range(255));
                else if (pick < 90)
                    push_cmd(OP_DISCARD, $urandom_range(127), $urandom_range(255));
                else
                    push_cmd(op_t'($urandom_range(3)), $urandom_range(127),
                             $urandom_range(255));
                made++;
            end
        end
    endtask

    // Stimulus sequence and final verdict
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed at reset capacity: data extremes, reads, empty and overlong cases
        gap_pct = 15;
        push_cmd(OP_WRITE, 3, 8'h00);
        push_cmd(OP_WRITE, 127, 8'hFF);
        push_cmd(OP_WRITE, 0, 8'hA5);
        push_cmd(OP_PREREAD, 3, 0);
        push_cmd(OP_READ, 2, 0);
        push_cmd(OP_READ, 5, 0);
        push_cmd(OP_READ, 0, 0);
        push_cmd(OP_PREREAD, 0, 0);
        push_cmd(OP_WRITE, 0, 8'h5A);
        push_cmd(OP_WRITE, 127, 8'h11);
        push_cmd(OP_WRITE, 64, 8'h22);
        push_cmd(OP_WRITE, 1, 8'h33);
        push_cmd(OP_READ, 1, 0);
        push_cmd(OP_DISCARD, 0, 0);
        drain();

        // directed at capacity written as zero, clamped to one: refusal, full buffer, cursor wrap
        write_capacity(0);
        push_cmd(OP_WRITE, 2, 8'h01);
        push_cmd(OP_WRITE, 2, 8'h02);
        push_cmd(OP_WRITE, 1, 8'h7E);
        push_cmd(OP_PREREAD, 1, 0);
        push_cmd(OP_WRITE, 1, 8'h99);
        push_cmd(OP_READ, 1, 0);
        push_cmd(OP_WRITE, 1, 8'hC3);
        push_cmd(OP_READ, 1, 0);
        drain();

        // random phases over several capacities and sender gap rates
        write_capacity(40);
        queue_random(21);
        drain();

        gap_pct = 61;
        write_capacity(8191);
        queue_random(21);
        drain();

        write_capacity(1);
        queue_random(21);
        drain();

        gap_pct = 0;
        write_capacity(4096);
        queue_random(21);
        drain();

        write_capacity(13);
        queue_random(21);
        drain();

        repeat (4) @(posedge clk);
        if (mismatches == 0 && owed_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
